@@ hdl/mic_pkg.sv @@
// shared types and encodings for the mips instruction classifier
// operation numbers, instruction classes, field encodings and the decode result struct
// no dependencies

package mic_pkg;

    typedef enum logic [5:0] {
        OP_NOP     = 6'd0,
        OP_SLL     = 6'd1,
        OP_OR      = 6'd2,
        OP_SLTU    = 6'd3,
        OP_ADDU    = 6'd4,
        OP_SLLV    = 6'd5,
        OP_AND     = 6'd6,
        OP_ADD     = 6'd7,
        OP_SUBU    = 6'd8,
        OP_SRA     = 6'd9,
        OP_DIV     = 6'd10,
        OP_MFLO    = 6'd11,
        OP_SRL     = 6'd12,
        OP_DIVU    = 6'd13,
        OP_MFHI    = 6'd14,
        OP_SLT     = 6'd15,
        OP_MTLO    = 6'd16,
        OP_MTHI    = 6'd17,
        OP_JR      = 6'd18,
        OP_JALR    = 6'd19,
        OP_SYSCALL = 6'd20,
        OP_BLTZ    = 6'd21,
        OP_BGEZ    = 6'd22,
        OP_MTC0    = 6'd23,
        OP_MFC0    = 6'd24,
        OP_RFE     = 6'd25,
        OP_LUI     = 6'd26,
        OP_ORI     = 6'd27,
        OP_SW      = 6'd28,
        OP_ADDIU   = 6'd29,
        OP_LHU     = 6'd30,
        OP_ADDI    = 6'd31,
        OP_LW      = 6'd32,
        OP_SH      = 6'd33,
        OP_ANDI    = 6'd34,
        OP_SB      = 6'd35,
        OP_LB      = 6'd36,
        OP_LBU     = 6'd37,
        OP_SLTI    = 6'd38,
        OP_SLTIU   = 6'd39,
        OP_J       = 6'd40,
        OP_JAL     = 6'd41,
        OP_BNE     = 6'd42,
        OP_BEQ     = 6'd43,
        OP_BGTZ    = 6'd44,
        OP_BLEZ    = 6'd45,
        OP_UNKNOWN = 6'd46
    } op_code_t;

    typedef enum logic [1:0] {
        CLS_NORMAL  = 2'd0,
        CLS_BRANCH  = 2'd1,
        CLS_SYSCALL = 2'd2
    } instr_class_t;

    // primary opcode field
    localparam logic [5:0] OPC_SPECIAL = 6'h00;
    localparam logic [5:0] OPC_REGIMM  = 6'h01;
    localparam logic [5:0] OPC_J       = 6'h02;
    localparam logic [5:0] OPC_JAL     = 6'h03;
    localparam logic [5:0] OPC_BEQ     = 6'h04;
    localparam logic [5:0] OPC_BNE     = 6'h05;
    localparam logic [5:0] OPC_BLEZ    = 6'h06;
    localparam logic [5:0] OPC_BGTZ    = 6'h07;
    localparam logic [5:0] OPC_ADDI    = 6'h08;
    localparam logic [5:0] OPC_ADDIU   = 6'h09;
    localparam logic [5:0] OPC_SLTI    = 6'h0A;
    localparam logic [5:0] OPC_SLTIU   = 6'h0B;
    localparam logic [5:0] OPC_ANDI    = 6'h0C;
    localparam logic [5:0] OPC_ORI     = 6'h0D;
    localparam logic [5:0] OPC_LUI     = 6'h0F;
    localparam logic [5:0] OPC_COP0    = 6'h10;
    localparam logic [5:0] OPC_LB      = 6'h20;
    localparam logic [5:0] OPC_LW      = 6'h23;
    localparam logic [5:0] OPC_LBU     = 6'h24;
    localparam logic [5:0] OPC_LHU     = 6'h25;
    localparam logic [5:0] OPC_SB      = 6'h28;
    localparam logic [5:0] OPC_SH      = 6'h29;
    localparam logic [5:0] OPC_SW      = 6'h2B;

    // special funct field
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;

    // regimm rt and cop0 rs selectors
    localparam logic [4:0] RT_BLTZ = 5'h00;
    localparam logic [4:0] RT_BGEZ = 5'h01;
    localparam logic [4:0] RS_MFC0 = 5'h00;
    localparam logic [4:0] RS_MTC0 = 5'h04;
    localparam logic [4:0] RS_RFE  = 5'h10;

    // register-use selectors
    localparam logic [3:0] USE_NONE = 4'b0000;
    localparam logic [3:0] USE_RS   = 4'b0001;
    localparam logic [3:0] USE_RT   = 4'b0010;
    localparam logic [3:0] USE_RD   = 4'b0100;
    localparam logic [3:0] USE_R31  = 4'b1000;

    localparam logic [31:0] PC_STEP = 32'd4;
    localparam logic [4:0]  LINK_REG = 5'd31;

    typedef struct packed {
        op_code_t     op_code;
        instr_class_t instr_class;
        logic [31:0]  reg_use_mask;
        logic         illegal;
        logic [4:0]   field_rs;
        logic [4:0]   field_rt;
        logic [4:0]   field_rd;
        logic [4:0]   field_sa;
        logic [5:0]   field_funct;
        logic [31:0]  instr_addr;
    } dec_result_t;

endpackage

@@ hdl/mic_decoder.sv @@
// combinational decode of one mips instruction word and its fetch pc
// produces the operation number, class, register mask, fields and address
// depends on mic_pkg

module mic_decoder (
    input  logic [31:0]         instr_word,
    input  logic [31:0]         compile_pc,
    output mic_pkg::dec_result_t result
);

    logic [5:0] opc;
    logic [4:0] rs;
    logic [4:0] rt;
    logic [4:0] rd;
    logic [4:0] sa;
    logic [5:0] funct;

    mic_pkg::op_code_t     op;
    mic_pkg::instr_class_t cls;
    logic [3:0]            use_sel;
    logic                  bad;
    logic [31:0]           mask;

    assign opc   = instr_word[31:26];
    assign rs    = instr_word[25:21];
    assign rt    = instr_word[20:16];
    assign rd    = instr_word[15:11];
    assign sa    = instr_word[10:6];
    assign funct = instr_word[5:0];

    always_comb begin
        op      = mic_pkg::OP_UNKNOWN;
        cls     = mic_pkg::CLS_NORMAL;
        use_sel = mic_pkg::USE_NONE;
        bad     = 1'b0;
        unique case (opc)
            mic_pkg::OPC_SPECIAL: begin
                unique case (funct)
                    mic_pkg::FN_SLL: begin
                        if (rt == 5'd0 && rd == 5'd0 && sa == 5'd0) begin
                            op = mic_pkg::OP_NOP;
                        end else begin
                            op      = mic_pkg::OP_SLL;
                            use_sel = mic_pkg::USE_RT | mic_pkg::USE_RD;
                        end
                    end
                    mic_pkg::FN_OR: begin
                        op      = mic_pkg::OP_OR;
                        use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT | mic_pkg::USE_RD;
                    end
                    mic_pkg::FN_SLTU: begin
                        op      = mic_pkg::OP_SLTU;
                        use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT | mic_pkg::USE_RD;
                    end
                    mic_pkg::FN_ADDU: begin
                        op      = mic_pkg::OP_ADDU;
                        use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT | mic_pkg::USE_RD;
                    end
                    mic_pkg::FN_SLLV: begin
                        op      = mic_pkg::OP_SLLV;
                        use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT | mic_pkg::USE_RD;
                    end
                    mic_pkg::FN_AND: begin
                        op      = mic_pkg::OP_AND;
                        use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT | mic_pkg::USE_RD;
                    end
                    mic_pkg::FN_ADD: begin
                        op      = mic_pkg::OP_ADD;
                        use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT | mic_pkg::USE_RD;
                    end
                    mic_pkg::FN_SUBU: begin
                        op      = mic_pkg::OP_SUBU;
                        use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT | mic_pkg::USE_RD;
                    end
                    mic_pkg::FN_SRA: begin
                        op      = mic_pkg::OP_SRA;
                        use_sel = mic_pkg::USE_RT | mic_pkg::USE_RD;
                    end
                    mic_pkg::FN_DIV: begin
                        op      = mic_pkg::OP_DIV;
                        use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
                    end
                    mic_pkg::FN_MFLO: begin
                        op      = mic_pkg::OP_MFLO;
                        use_sel = mic_pkg::USE_RD;
                    end
                    mic_pkg::FN_SRL: begin
                        op      = mic_pkg::OP_SRL;
                        use_sel = mic_pkg::USE_RT | mic_pkg::USE_RD;
                    end
                    mic_pkg::FN_DIVU: begin
                        op      = mic_pkg::OP_DIVU;
                        use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
                    end
                    mic_pkg::FN_MFHI: begin
                        op      = mic_pkg::OP_MFHI;
                        use_sel = mic_pkg::USE_RD;
                    end
                    mic_pkg::FN_SLT: begin
                        op      = mic_pkg::OP_SLT;
                        use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT | mic_pkg::USE_RD;
                    end
                    mic_pkg::FN_MTLO: begin
                        op      = mic_pkg::OP_MTLO;
                        use_sel = mic_pkg::USE_RS;
                    end
                    mic_pkg::FN_MTHI: begin
                        op      = mic_pkg::OP_MTHI;
                        use_sel = mic_pkg::USE_RS;
                    end
                    mic_pkg::FN_JR: begin
                        op      = mic_pkg::OP_JR;
                        cls     = mic_pkg::CLS_BRANCH;
                        use_sel = mic_pkg::USE_RS;
                    end
                    mic_pkg::FN_JALR: begin
                        op      = mic_pkg::OP_JALR;
                        cls     = mic_pkg::CLS_BRANCH;
                        use_sel = mic_pkg::USE_RS | mic_pkg::USE_RD;
                    end
                    mic_pkg::FN_SYSCALL: begin
                        op  = mic_pkg::OP_SYSCALL;
                        cls = mic_pkg::CLS_SYSCALL;
                    end
                    default: begin
                        bad = 1'b1;
                    end
                endcase
            end
            mic_pkg::OPC_REGIMM: begin
                if (rt == mic_pkg::RT_BLTZ) begin
                    op      = mic_pkg::OP_BLTZ;
                    cls     = mic_pkg::CLS_BRANCH;
                    use_sel = mic_pkg::USE_RS;
                end else if (rt == mic_pkg::RT_BGEZ) begin
                    op      = mic_pkg::OP_BGEZ;
                    cls     = mic_pkg::CLS_BRANCH;
                    use_sel = mic_pkg::USE_RS;
                end else begin
                    bad = 1'b1;
                end
            end
            mic_pkg::OPC_COP0: begin
                if (rs == mic_pkg::RS_MTC0) begin
                    op      = mic_pkg::OP_MTC0;
                    use_sel = mic_pkg::USE_RT;
                end else if (rs == mic_pkg::RS_MFC0) begin
                    op      = mic_pkg::OP_MFC0;
                    use_sel = mic_pkg::USE_RT;
                end else if (rs == mic_pkg::RS_RFE) begin
                    op = mic_pkg::OP_RFE;
                end else begin
                    bad = 1'b1;
                end
            end
            mic_pkg::OPC_LUI: begin
                op      = mic_pkg::OP_LUI;
                use_sel = mic_pkg::USE_RT;
            end
            mic_pkg::OPC_ORI: begin
                op      = mic_pkg::OP_ORI;
                use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
            end
            mic_pkg::OPC_SW: begin
                op      = mic_pkg::OP_SW;
                use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
            end
            mic_pkg::OPC_ADDIU: begin
                op      = mic_pkg::OP_ADDIU;
                use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
            end
            mic_pkg::OPC_LHU: begin
                op      = mic_pkg::OP_LHU;
                use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
            end
            mic_pkg::OPC_ADDI: begin
                op      = mic_pkg::OP_ADDI;
                use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
            end
            mic_pkg::OPC_LW: begin
                op      = mic_pkg::OP_LW;
                use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
            end
            mic_pkg::OPC_SH: begin
                op      = mic_pkg::OP_SH;
                use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
            end
            mic_pkg::OPC_ANDI: begin
                op      = mic_pkg::OP_ANDI;
                use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
            end
            mic_pkg::OPC_SB: begin
                op      = mic_pkg::OP_SB;
                use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
            end
            mic_pkg::OPC_LB: begin
                op      = mic_pkg::OP_LB;
                use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
            end
            mic_pkg::OPC_LBU: begin
                op      = mic_pkg::OP_LBU;
                use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
            end
            mic_pkg::OPC_SLTI: begin
                op      = mic_pkg::OP_SLTI;
                use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
            end
            mic_pkg::OPC_SLTIU: begin
                op      = mic_pkg::OP_SLTIU;
                use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
            end
            mic_pkg::OPC_J: begin
                op  = mic_pkg::OP_J;
                cls = mic_pkg::CLS_BRANCH;
            end
            mic_pkg::OPC_JAL: begin
                op      = mic_pkg::OP_JAL;
                cls     = mic_pkg::CLS_BRANCH;
                use_sel = mic_pkg::USE_R31;
            end
            mic_pkg::OPC_BNE: begin
                op      = mic_pkg::OP_BNE;
                cls     = mic_pkg::CLS_BRANCH;
                use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
            end
            mic_pkg::OPC_BEQ: begin
                op      = mic_pkg::OP_BEQ;
                cls     = mic_pkg::CLS_BRANCH;
                use_sel = mic_pkg::USE_RS | mic_pkg::USE_RT;
            end
            mic_pkg::OPC_BGTZ: begin
                op      = mic_pkg::OP_BGTZ;
                cls     = mic_pkg::CLS_BRANCH;
                use_sel = mic_pkg::USE_RS;
            end
            mic_pkg::OPC_BLEZ: begin
                op      = mic_pkg::OP_BLEZ;
                cls     = mic_pkg::CLS_BRANCH;
                use_sel = mic_pkg::USE_RS;
            end
            default: begin
                bad = 1'b1;
            end
        endcase
    end

    // one-hot register decode, or-ed per named field
    always_comb begin
        mask = 32'd0;
        if ((use_sel & mic_pkg::USE_RS) != 4'd0) begin
            mask = mask | (32'd1 << rs);
        end
        if ((use_sel & mic_pkg::USE_RT) != 4'd0) begin
            mask = mask | (32'd1 << rt);
        end
        if ((use_sel & mic_pkg::USE_RD) != 4'd0) begin
            mask = mask | (32'd1 << rd);
        end
        if ((use_sel & mic_pkg::USE_R31) != 4'd0) begin
            mask = mask | (32'd1 << mic_pkg::LINK_REG);
        end
    end

    always_comb begin
        result.op_code      = op;
        result.instr_class  = cls;
        result.reg_use_mask = mask;
        result.illegal      = bad;
        result.field_rs     = rs;
        result.field_rt     = rt;
        result.field_rd     = rd;
        result.field_sa     = sa;
        result.field_funct  = funct;
        result.instr_addr   = compile_pc - mic_pkg::PC_STEP;
    end

endmodule

@@ hdl/mips_instruction_classifier.sv @@
// top level of the mips instruction classifier: input register, decoder, result register
// depends on mic_pkg and mic_decoder

// Classifies one MIPS R3000 instruction per transaction. An accepted word is held in an
// input register, decoded by a single combinational pass and captured in a result
// register, from which it is offered on m_tvalid until it is taken on m_tready. One
// transaction can be accepted every cycle while m_tready does not hold a result back;
// that figure is set by the one decode stage between the two registers.
// The input register holds on to its word only while a finished result waits on
// m_tready, so an empty input register still takes a new word during such a wait.
// Unsupported encodings give operation 46, class normal, an empty register mask and
// the illegal flag set.

module mips_instruction_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // instr_word [31:0], compile_pc [63:32]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // op_code [5:0], reg_use_mask [37:6], field_rs [42:38], field_rt [47:43],
    // field_rd [52:48], field_sa [57:53], field_funct [63:58], instr_addr [95:64]
    output logic [95:0] m_tdata,
    // instr_class [1:0], illegal [2]
    output logic [2:0]  m_tuser
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [31:0]          in_word_reg;
    logic [31:0]          in_pc_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    mic_pkg::dec_result_t out_res_reg;
    mic_pkg::dec_result_t dec_res;
    logic                 out_ready;
    logic                 in_load;
    logic                 out_load;

    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign in_load   = s_tvalid && s_tready;
    assign out_load  = in_valid_reg && out_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_word_reg <= s_tdata[31:0];
            in_pc_reg   <= s_tdata[63:32];
        end
        if (out_load) begin
            out_res_reg <= dec_res;
        end
    end

    mic_decoder u_decoder (
        .instr_word (in_word_reg),
        .compile_pc (in_pc_reg),
        .result     (dec_res)
    );

    assign m_tvalid       = out_valid_reg;
    assign m_tdata[5:0]   = out_res_reg.op_code;
    assign m_tdata[37:6]  = out_res_reg.reg_use_mask;
    assign m_tdata[42:38] = out_res_reg.field_rs;
    assign m_tdata[47:43] = out_res_reg.field_rt;
    assign m_tdata[52:48] = out_res_reg.field_rd;
    assign m_tdata[57:53] = out_res_reg.field_sa;
    assign m_tdata[63:58] = out_res_reg.field_funct;
    assign m_tdata[95:64] = out_res_reg.instr_addr;
    assign m_tuser[1:0]   = out_res_reg.instr_class;
    assign m_tuser[2]     = out_res_reg.illegal;

endmodule

@@ test/testbench.sv @@
// stream testbench for mips_instruction_classifier: directed corner words, then random traffic
// mostly with random idling on both channels; all results checked by an internal decode predictor
// depends on mic_pkg and the classifier rtl

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // instr_word [31:0], compile_pc [63:32]
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // op_code [5:0], reg_use_mask [37:6], field_rs [42:38], field_rt [47:43],
    // field_rd [52:48], field_sa [57:53], field_funct [63:58], instr_addr [95:64]
    logic [95:0] m_tdata;
    // instr_class [1:0], illegal [2]
    logic [2:0]  m_tuser;

    mic_pkg::dec_result_t pending_decodes[$];
    mic_pkg::dec_result_t want;
    int                   mismatch_count = 0;
    int                   quiet_cycles = 0;
    logic                 steady = 1'b0;

    mips_instruction_classifier u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic mic_pkg::dec_result_t predict_decode(logic [31:0] w, logic [31:0] pc);
        mic_pkg::dec_result_t r;
        mic_pkg::op_code_t    op;
        logic [3:0]           uses;
        logic [31:0]          mask;
        op = mic_pkg::OP_UNKNOWN;
        case (w[31:26])
            mic_pkg::OPC_SPECIAL: begin
                case (w[5:0])
                    mic_pkg::FN_SLL:
                        op = (w[20:6] == 15'd0) ? mic_pkg::OP_NOP : mic_pkg::OP_SLL;
                    mic_pkg::FN_OR:      op = mic_pkg::OP_OR;
                    mic_pkg::FN_SLTU:    op = mic_pkg::OP_SLTU;
                    mic_pkg::FN_ADDU:    op = mic_pkg::OP_ADDU;
                    mic_pkg::FN_SLLV:    op = mic_pkg::OP_SLLV;
                    mic_pkg::FN_AND:     op = mic_pkg::OP_AND;
                    mic_pkg::FN_ADD:     op = mic_pkg::OP_ADD;
                    mic_pkg::FN_SUBU:    op = mic_pkg::OP_SUBU;
                    mic_pkg::FN_SRA:     op = mic_pkg::OP_SRA;
                    mic_pkg::FN_DIV:     op = mic_pkg::OP_DIV;
                    mic_pkg::FN_MFLO:    op = mic_pkg::OP_MFLO;
                    mic_pkg::FN_SRL:     op = mic_pkg::OP_SRL;
                    mic_pkg::FN_DIVU:    op = mic_pkg::OP_DIVU;
                    mic_pkg::FN_MFHI:    op = mic_pkg::OP_MFHI;
                    mic_pkg::FN_SLT:     op = mic_pkg::OP_SLT;
                    mic_pkg::FN_MTLO:    op = mic_pkg::OP_MTLO;
                    mic_pkg::FN_MTHI:    op = mic_pkg::OP_MTHI;
                    mic_pkg::FN_JR:      op = mic_pkg::OP_JR;
                    mic_pkg::FN_JALR:    op = mic_pkg::OP_JALR;
                    mic_pkg::FN_SYSCALL: op = mic_pkg::OP_SYSCALL;
                    default:             op = mic_pkg::OP_UNKNOWN;
                endcase
            end
            mic_pkg::OPC_REGIMM: begin
                if (w[20:16] == mic_pkg::RT_BLTZ) op = mic_pkg::OP_BLTZ;
                else if (w[20:16] == mic_pkg::RT_BGEZ) op = mic_pkg::OP_BGEZ;
            end
            mic_pkg::OPC_COP0: begin
                if (w[25:21] == mic_pkg::RS_MTC0) op = mic_pkg::OP_MTC0;
                else if (w[25:21] == mic_pkg::RS_MFC0) op = mic_pkg::OP_MFC0;
                else if (w[25:21] == mic_pkg::RS_RFE) op = mic_pkg::OP_RFE;
            end
            mic_pkg::OPC_LUI:   op = mic_pkg::OP_LUI;
            mic_pkg::OPC_ORI:   op = mic_pkg::OP_ORI;
            mic_pkg::OPC_SW:    op = mic_pkg::OP_SW;
            mic_pkg::OPC_ADDIU: op = mic_pkg::OP_ADDIU;
            mic_pkg::OPC_LHU:   op = mic_pkg::OP_LHU;
            mic_pkg::OPC_ADDI:  op = mic_pkg::OP_ADDI;
            mic_pkg::OPC_LW:    op = mic_pkg::OP_LW;
            mic_pkg::OPC_SH:    op = mic_pkg::OP_SH;
            mic_pkg::OPC_ANDI:  op = mic_pkg::OP_ANDI;
            mic_pkg::OPC_SB:    op = mic_pkg::OP_SB;
            mic_pkg::OPC_LB:    op = mic_pkg::OP_LB;
            mic_pkg::OPC_LBU:   op = mic_pkg::OP_LBU;
            mic_pkg::OPC_SLTI:  op = mic_pkg::OP_SLTI;
            mic_pkg::OPC_SLTIU: op = mic_pkg::OP_SLTIU;
            mic_pkg::OPC_J:     op = mic_pkg::OP_J;
            mic_pkg::OPC_JAL:   op = mic_pkg::OP_JAL;
            mic_pkg::OPC_BNE:   op = mic_pkg::OP_BNE;
            mic_pkg::OPC_BEQ:   op = mic_pkg::OP_BEQ;
            mic_pkg::OPC_BGTZ:  op = mic_pkg::OP_BGTZ;
            mic_pkg::OPC_BLEZ:  op = mic_pkg::OP_BLEZ;
            default:            op = mic_pkg::OP_UNKNOWN;
        endcase

        case (op) inside
            mic_pkg::OP_SLL, mic_pkg::OP_SRA, mic_pkg::OP_SRL:
                uses = mic_pkg::USE_RT | mic_pkg::USE_RD;
            mic_pkg::OP_OR, mic_pkg::OP_SLTU, mic_pkg::OP_ADDU, mic_pkg::OP_SLLV,
            mic_pkg::OP_AND, mic_pkg::OP_ADD, mic_pkg::OP_SUBU, mic_pkg::OP_SLT:
                uses = mic_pkg::USE_RS | mic_pkg::USE_RT | mic_pkg::USE_RD;
            mic_pkg::OP_DIV, mic_pkg::OP_DIVU, mic_pkg::OP_ORI, mic_pkg::OP_SW,
            mic_pkg::OP_ADDIU, mic_pkg::OP_LHU, mic_pkg::OP_ADDI, mic_pkg::OP_LW,
            mic_pkg::OP_SH, mic_pkg::OP_ANDI, mic_pkg::OP_SB, mic_pkg::OP_LB,
            mic_pkg::OP_LBU, mic_pkg::OP_SLTI, mic_pkg::OP_SLTIU, mic_pkg::OP_BNE,
            mic_pkg::OP_BEQ:
                uses = mic_pkg::USE_RS | mic_pkg::USE_RT;
            mic_pkg::OP_MFLO, mic_pkg::OP_MFHI:
                uses = mic_pkg::USE_RD;
            mic_pkg::OP_MTLO, mic_pkg::OP_MTHI, mic_pkg::OP_JR, mic_pkg::OP_BLTZ,
            mic_pkg::OP_BGEZ, mic_pkg::OP_BGTZ, mic_pkg::OP_BLEZ:
                uses = mic_pkg::USE_RS;
            mic_pkg::OP_JALR:
                uses = mic_pkg::USE_RS | mic_pkg::USE_RD;
            mic_pkg::OP_MTC0, mic_pkg::OP_MFC0, mic_pkg::OP_LUI:
                uses = mic_pkg::USE_RT;
            mic_pkg::OP_JAL:
                uses = mic_pkg::USE_R31;
            default:
                uses = mic_pkg::USE_NONE;
        endcase

        mask = '0;
        if ((uses & mic_pkg::USE_RS) != mic_pkg::USE_NONE) mask |= 32'd1 << w[25:21];
        if ((uses & mic_pkg::USE_RT) != mic_pkg::USE_NONE) mask |= 32'd1 << w[20:16];
        if ((uses & mic_pkg::USE_RD) != mic_pkg::USE_NONE) mask |= 32'd1 << w[15:11];
        if ((uses & mic_pkg::USE_R31) != mic_pkg::USE_NONE) begin
            mask |= 32'd1 << mic_pkg::LINK_REG;
        end

        case (op) inside
            mic_pkg::OP_JR, mic_pkg::OP_JALR, mic_pkg::OP_BLTZ, mic_pkg::OP_BGEZ,
            mic_pkg::OP_J, mic_pkg::OP_JAL, mic_pkg::OP_BNE, mic_pkg::OP_BEQ,
            mic_pkg::OP_BGTZ, mic_pkg::OP_BLEZ:
                r.instr_class = mic_pkg::CLS_BRANCH;
            mic_pkg::OP_SYSCALL:
                r.instr_class = mic_pkg::CLS_SYSCALL;
            default:
                r.instr_class = mic_pkg::CLS_NORMAL;
        endcase

        r.op_code      = op;
        r.reg_use_mask = mask;
        r.illegal      = (op == mic_pkg::OP_UNKNOWN);
        r.field_rs     = w[25:21];
        r.field_rt     = w[20:16];
        r.field_rd     = w[15:11];
        r.field_sa     = w[10:6];
        r.field_funct  = w[5:0];
        r.instr_addr   = pc - mic_pkg::PC_STEP;
        return r;
    endfunction

    // random well-formed word for one operation, free fields random
    function automatic logic [31:0] build_word(mic_pkg::op_code_t op);
        logic [31:0] w;
        w = $urandom();
        case (op)
            mic_pkg::OP_NOP: begin
                w[31:26] = mic_pkg::OPC_SPECIAL;
                w[20:0]  = {15'd0, mic_pkg::FN_SLL};
            end
            mic_pkg::OP_SLL: begin
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_SLL};
                if (w[20:6] == 15'd0) w[5'(6 + $urandom_range(0, 14))] = 1'b1;
            end
            mic_pkg::OP_OR:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_OR};
            mic_pkg::OP_SLTU:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_SLTU};
            mic_pkg::OP_ADDU:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_ADDU};
            mic_pkg::OP_SLLV:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_SLLV};
            mic_pkg::OP_AND:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_AND};
            mic_pkg::OP_ADD:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_ADD};
            mic_pkg::OP_SUBU:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_SUBU};
            mic_pkg::OP_SRA:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_SRA};
            mic_pkg::OP_DIV:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_DIV};
            mic_pkg::OP_MFLO:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_MFLO};
            mic_pkg::OP_SRL:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_SRL};
            mic_pkg::OP_DIVU:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_DIVU};
            mic_pkg::OP_MFHI:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_MFHI};
            mic_pkg::OP_SLT:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_SLT};
            mic_pkg::OP_MTLO:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_MTLO};
            mic_pkg::OP_MTHI:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_MTHI};
            mic_pkg::OP_JR:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_JR};
            mic_pkg::OP_JALR:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_JALR};
            mic_pkg::OP_SYSCALL:
                {w[31:26], w[5:0]} = {mic_pkg::OPC_SPECIAL, mic_pkg::FN_SYSCALL};
            mic_pkg::OP_BLTZ: begin
                w[31:26] = mic_pkg::OPC_REGIMM;
                w[20:16] = mic_pkg::RT_BLTZ;
            end
            mic_pkg::OP_BGEZ: begin
                w[31:26] = mic_pkg::OPC_REGIMM;
                w[20:16] = mic_pkg::RT_BGEZ;
            end
            mic_pkg::OP_MTC0:  w[31:21] = {mic_pkg::OPC_COP0, mic_pkg::RS_MTC0};
            mic_pkg::OP_MFC0:  w[31:21] = {mic_pkg::OPC_COP0, mic_pkg::RS_MFC0};
            mic_pkg::OP_RFE:   w[31:21] = {mic_pkg::OPC_COP0, mic_pkg::RS_RFE};
            mic_pkg::OP_LUI:   w[31:26] = mic_pkg::OPC_LUI;
            mic_pkg::OP_ORI:   w[31:26] = mic_pkg::OPC_ORI;
            mic_pkg::OP_SW:    w[31:26] = mic_pkg::OPC_SW;
            mic_pkg::OP_ADDIU: w[31:26] = mic_pkg::OPC_ADDIU;
            mic_pkg::OP_LHU:   w[31:26] = mic_pkg::OPC_LHU;
            mic_pkg::OP_ADDI:  w[31:26] = mic_pkg::OPC_ADDI;
            mic_pkg::OP_LW:    w[31:26] = mic_pkg::OPC_LW;
            mic_pkg::OP_SH:    w[31:26] = mic_pkg::OPC_SH;
            mic_pkg::OP_ANDI:  w[31:26] = mic_pkg::OPC_ANDI;
            mic_pkg::OP_SB:    w[31:26] = mic_pkg::OPC_SB;
            mic_pkg::OP_LB:    w[31:26] = mic_pkg::OPC_LB;
            mic_pkg::OP_LBU:   w[31:26] = mic_pkg::OPC_LBU;
            mic_pkg::OP_SLTI:  w[31:26] = mic_pkg::OPC_SLTI;
            mic_pkg::OP_SLTIU: w[31:26] = mic_pkg::OPC_SLTIU;
            mic_pkg::OP_J:     w[31:26] = mic_pkg::OPC_J;
            mic_pkg::OP_JAL:   w[31:26] = mic_pkg::OPC_JAL;
            mic_pkg::OP_BNE:   w[31:26] = mic_pkg::OPC_BNE;
            mic_pkg::OP_BEQ:   w[31:26] = mic_pkg::OPC_BEQ;
            mic_pkg::OP_BGTZ:  w[31:26] = mic_pkg::OPC_BGTZ;
            mic_pkg::OP_BLEZ:  w[31:26] = mic_pkg::OPC_BLEZ;
            default:           w = 32'hFFFF_FFFF;
        endcase
        return w;
    endfunction

    // mostly random pcs, some near zero and near the top to exercise the wrap
    function automatic logic [31:0] pick_pc();
        case ($urandom_range(0, 9))
            0:       return 32'($urandom_range(0, 7));
            1:       return 32'hFFFF_FFF8 + 32'($urandom_range(0, 7));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_word(input logic [31:0] word, input logic [31:0] pc);
        while (!steady && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pc, word};
        do @(posedge aclk); while (!s_tready);
        pending_decodes.push_back(predict_decode(word, pc));
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s: expected %h, got %h", what, exp_v, got_v);
        end
    endtask

    // result side: random back-pressure outside the steady stretch, and field-by-field comparison
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_decodes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: result transaction with nothing pending");
                end else begin
                    want = pending_decodes.pop_front();
                    check_field("op_code", 32'(want.op_code), 32'(m_tdata[5:0]));
                    check_field("instr_class", 32'(want.instr_class), 32'(m_tuser[1:0]));
                    check_field("reg_use_mask", want.reg_use_mask, m_tdata[37:6]);
                    check_field("illegal", 32'(want.illegal), 32'(m_tuser[2]));
                    check_field("field_rs", 32'(want.field_rs), 32'(m_tdata[42:38]));
                    check_field("field_rt", 32'(want.field_rt), 32'(m_tdata[47:43]));
                    check_field("field_rd", 32'(want.field_rd), 32'(m_tdata[52:48]));
                    check_field("field_sa", 32'(want.field_sa), 32'(m_tdata[57:53]));
                    check_field("field_funct", 32'(want.field_funct), 32'(m_tdata[63:58]));
                    check_field("instr_addr", want.instr_addr, m_tdata[95:64]);
                end
            end
            m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 23);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic test_special_cases();
        send_word(32'h0000_0000, 32'h0000_0000);
        send_word({mic_pkg::OPC_SPECIAL, 5'd31, 15'd0, mic_pkg::FN_SLL}, 32'hFFFF_FFFF);
        send_word({mic_pkg::OPC_SPECIAL, 5'd0, 5'd0, 5'd0, 5'd1, mic_pkg::FN_SLL},
                  32'h0000_0004);
        send_word({mic_pkg::OPC_SPECIAL, 5'd0, 5'd31, 5'd0, 5'd0, mic_pkg::FN_SLL},
                  32'h0000_0003);
        send_word({mic_pkg::OPC_SPECIAL, 5'd0, 5'd0, 5'd31, 5'd0, mic_pkg::FN_SLL},
                  32'h8000_0000);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFC);
        send_word({mic_pkg::OPC_SPECIAL, 20'hFFFFF, mic_pkg::FN_SYSCALL}, 32'h1234_5678);
        send_word({mic_pkg::OPC_JAL, 26'h3FF_FFFF}, 32'hBFC0_0004);
        send_word({mic_pkg::OPC_J, 26'h000_0000}, 32'h0000_0001);
        send_word({mic_pkg::OPC_SPECIAL, 5'd31, 5'd0, 5'd0, 5'd0, mic_pkg::FN_JALR},
                  32'h0000_0002);
        send_word({mic_pkg::OPC_SPECIAL, 5'd0, 5'd0, 5'd0, 5'd0, mic_pkg::FN_ADDU},
                  32'h7FFF_FFFF);
        send_word({mic_pkg::OPC_SPECIAL, 5'd31, 5'd31, 5'd31, 5'd31, mic_pkg::FN_OR},
                  32'hFFFF_FFFF);
        send_word({mic_pkg::OPC_COP0, mic_pkg::RS_RFE, 15'd0, 6'h10}, 32'h8000_0080);
        send_word({mic_pkg::OPC_COP0, mic_pkg::RS_MTC0, 5'd31, 5'd12, 11'd0}, 32'h0000_0100);
        send_word({mic_pkg::OPC_COP0, mic_pkg::RS_MFC0, 5'd0, 5'd13, 11'd0}, 32'h0000_0200);
        send_word({mic_pkg::OPC_COP0, 5'h1F, 21'h1F_FFFF}, 32'h0000_0300);
        send_word({mic_pkg::OPC_REGIMM, 5'd4, 5'd2, 16'hFFFF}, 32'h0000_0400);
        send_word({mic_pkg::OPC_REGIMM, 5'd31, mic_pkg::RT_BLTZ, 16'h8000}, 32'h0000_0500);
        send_word({mic_pkg::OPC_REGIMM, 5'd0, mic_pkg::RT_BGEZ, 16'h7FFF}, 32'h0000_0600);
        send_word({mic_pkg::OPC_SPECIAL, 20'hFFFFF, 6'h3F}, 32'h0000_0700);
        send_word({mic_pkg::OPC_SPECIAL, 20'h00000, 6'h01}, 32'h0000_0800);
        send_word({mic_pkg::OPC_LUI, 5'd31, 5'd31, 16'hFFFF}, 32'h0000_0900);
        send_word({mic_pkg::OPC_BLEZ, 5'd31, 5'd31, 16'h0000}, 32'h0000_0A00);
        send_word({mic_pkg::OPC_BGTZ, 5'd0, 5'd0, 16'hFFFF}, 32'h0000_0B00);
    endtask

    task automatic test_legal_stream(input int count);
        repeat (count)
            send_word(build_word(mic_pkg::op_code_t'(6'($urandom_range(0, 45)))), pick_pc());
    endtask

    task automatic test_broken_encodings(input int count);
        logic [31:0] w;
        repeat (count) begin
            w = $urandom();
            case ($urandom_range(0, 3))
                1:       w[31:26] = mic_pkg::OPC_SPECIAL;
                2:       w[31:26] = mic_pkg::OPC_REGIMM;
                3:       w[31:26] = mic_pkg::OPC_COP0;
                default: ;
            endcase
            send_word(w, pick_pc());
        end
    endtask

    // long stretch with both sides always ready, mostly legal words
    task automatic test_back_to_back(input int count);
        steady <= 1'b1;
        repeat (count) begin
            if ($urandom_range(0, 9) == 0)
                send_word($urandom(), pick_pc());
            else
                send_word(build_word(mic_pkg::op_code_t'(6'($urandom_range(0, 45)))),
                          pick_pc());
        end
        steady <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_special_cases();
        test_legal_stream(550);
        test_back_to_back(180);
        test_broken_encodings(200);

        s_tvalid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
